/* rtl/core/spq_pkg.sv */
package spq_pkg;

  localparam int unsigned PRIMARY_BITS   = 8;
  localparam int unsigned SECONDARY_BITS = 16;
  localparam int unsigned TAG_BITS       = 16;
  localparam int unsigned OCC_BITS       = 5;
  localparam int unsigned QUEUE_DEPTH    = 16;

  typedef enum logic {
    CMD_ENQUEUE = 1'b0,
    CMD_DEQUEUE = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [PRIMARY_BITS-1:0]   pri;
    logic [SECONDARY_BITS-1:0] sec;
    logic [TAG_BITS-1:0]       tag;
  } spq_entry_t;

  // per-cycle shift control broadcast along the chain
  typedef struct packed {
    logic enq;  // enqueue accepted and queue not full
    logic deq;  // dequeue accepted and queue not empty
  } spq_ctrl_t;

endpackage

/* rtl/core/spq_in_if.sv */
interface spq_in_if;
  import spq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic [PRIMARY_BITS-1:0]   primary_key;
  logic [SECONDARY_BITS-1:0] secondary_key;
  logic [TAG_BITS-1:0]       entry_tag;

  modport source (output valid, cmd, primary_key, secondary_key, entry_tag, input ready);
  modport sink   (input valid, cmd, primary_key, secondary_key, entry_tag, output ready);
endinterface

/* rtl/core/spq_out_if.sv */
interface spq_out_if;
  import spq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      ok;
  logic                      head_valid;
  logic [PRIMARY_BITS-1:0]   head_primary;
  logic [SECONDARY_BITS-1:0] head_secondary;
  logic [TAG_BITS-1:0]       head_tag;
  logic [OCC_BITS-1:0]       occupancy;

  modport source (output valid, ok, head_valid, head_primary, head_secondary, head_tag,
                  occupancy, input ready);
  modport sink   (input valid, ok, head_valid, head_primary, head_secondary, head_tag,
                  occupancy, output ready);
endinterface

/* rtl/core/spq_cell.sv */
module spq_cell (
  input  logic               clk,
  input  spq_pkg::spq_ctrl_t ctrl,
  input  logic               live,
  input  spq_pkg::spq_entry_t new_entry,
  input  logic               ins_left,
  input  spq_pkg::spq_entry_t left_entry,
  input  spq_pkg::spq_entry_t right_entry,
  output logic               ins,
  output spq_pkg::spq_entry_t entry
);
  import spq_pkg::*;

  logic goes_before;

  // new key pair served strictly before the held one
  assign goes_before = (new_entry.pri < entry.pri) ||
                       ((new_entry.pri == entry.pri) && (new_entry.sec < entry.sec));

  // insertion point is at or left of this cell
  assign ins = !live || goes_before;

  always_ff @(posedge clk) begin
    if (ctrl.deq) begin
      entry <= right_entry;
    end else if (ctrl.enq && ins) begin
      if (ins_left) begin
        entry <= left_entry;
      end else begin
        entry <= new_entry;
      end
    end
  end

endmodule

/* rtl/core/sorted_priority_queue.sv */
// sorted priority queue, kept as a chain of entry cells ordered head first
//
// channels: in (sink) carries cmd, primary_key, secondary_key, entry_tag;
// out (source) carries ok, head_valid, head_primary, head_secondary,
// head_tag and occupancy. a transaction completes when valid and ready are
// both high at a rising edge of clk
//
// every input transaction yields exactly one output transaction. the result
// is registered, so it appears in the cycle after acceptance. one item per
// cycle is taken while the receiver keeps up: every cell compares the new key
// pair with its own entry in parallel and shifts by one place, so the
// comparator in each cell sets the pace
//
// when the receiver stalls, the result register holds and in.ready drops
// until the result is taken; in.ready is high whenever the result register is
// empty or being emptied in the same cycle
//
// rst (synchronous, active high) empties the queue and the result register;
// cell contents are not cleared, cells beyond the occupancy count are ignored
module sorted_priority_queue #(
  parameter int unsigned QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  spq_in_if.sink    in,
  spq_out_if.source out
);
  import spq_pkg::*;

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  // occupancy count, the only reset state of the store
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  spq_entry_t entries [QUEUE_DEPTH];
  logic       ins     [QUEUE_DEPTH];

  spq_entry_t new_entry;
  spq_ctrl_t  ctrl;
  logic       accept;
  logic       full;
  logic       empty;
  logic       ok_next;
  logic       head_valid_next;
  spq_entry_t head_next;

  assign accept = in.valid && in.ready;
  assign in.ready = !out.valid || out.ready;

  assign full  = (count == CW'(QUEUE_DEPTH));
  assign empty = (count == '0);

  assign new_entry.pri = in.primary_key;
  assign new_entry.sec = in.secondary_key;
  assign new_entry.tag = in.entry_tag;

  assign ctrl.enq = accept && (cmd_t'(in.cmd) == CMD_ENQUEUE) && !full;
  assign ctrl.deq = accept && (cmd_t'(in.cmd) == CMD_DEQUEUE) && !empty;
  assign ok_next  = ctrl.enq || ctrl.deq;

  // the chain of cells: entries shift right on insert and left on removal
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .live        (CW'(i) < count),
      .new_entry   (new_entry),
      .ins_left    ((i == 0) ? 1'b0 : ins[(i == 0) ? 0 : i - 1]),
      .left_entry  (entries[(i == 0) ? 0 : i - 1]),
      .right_entry (entries[(i == QUEUE_DEPTH - 1) ? i : i + 1]),
      .ins         (ins[i]),
      .entry       (entries[i])
    );
  end

  always_comb begin
    count_next = count;
    if (ctrl.enq) begin
      count_next = count + CW'(1);
    end else if (ctrl.deq) begin
      count_next = count - CW'(1);
    end
  end

  // head after the operation, taken from the cells' next values
  always_comb begin
    head_next = entries[0];
    if (ctrl.enq && ins[0]) begin
      head_next = new_entry;
    end else if (ctrl.deq) begin
      head_next = entries[1];
    end
    head_valid_next = (count_next != '0);
    if (!head_valid_next) begin
      head_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out.valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out.valid <= 1'b1;
      end else if (out.ready) begin
        out.valid <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      out.ok             <= ok_next;
      out.head_valid     <= head_valid_next;
      out.head_primary   <= head_next.pri;
      out.head_secondary <= head_next.sec;
      out.head_tag       <= head_next.tag;
      out.occupancy      <= OCC_BITS'(32'(count_next));
    end
  end

endmodule
